// ===== rtl/psist_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psist_pkg
// Shared types, codes and the table-kind lookup of the PSI section tracker.
// ----------------------------------------------------------------------------
package psist_pkg;

    // status codes
    localparam logic [1:0] ST_REJECT    = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_SEEN      = 2'd2;
    localparam logic [1:0] ST_NEW       = 2'd3;

    // table kind codes
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_PAT   = 3'd1;
    localparam logic [2:0] KIND_PMT   = 3'd2;
    localparam logic [2:0] KIND_NIT   = 3'd3;
    localparam logic [2:0] KIND_SDT   = 3'd4;

    // table ids
    localparam logic [7:0] TID_PAT       = 8'h00;
    localparam logic [7:0] TID_PMT       = 8'h02;
    localparam logic [7:0] TID_NIT_ACT   = 8'h40;
    localparam logic [7:0] TID_NIT_OTH   = 8'h41;
    localparam logic [7:0] TID_SDT_ACT   = 8'h42;
    localparam logic [7:0] TID_SDT_OTH   = 8'h46;

    // header after the length field plus CRC
    localparam logic [11:0] HDR_CRC_LEN = 12'd9;

    // configuration register indexes
    localparam logic CFG_EXP_TID = 1'b0;
    localparam logic CFG_SEGMENTED = 1'b1;

    typedef struct packed {
        logic [7:0]  tbl_id;
        logic [15:0] tbl_ext;
        logic [4:0]  ver_num;
        logic [7:0]  sec_num;
        logic [7:0]  last_sec;
        logic [11:0] sec_len;
    } t_sec_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        version_reset;
        logic [2:0]  table_kind;
        logic [11:0] payload_length;
        logic        table_complete;
    } t_sec_out;

    // bitmap control from the tracker
    typedef struct packed {
        logic       clear;
        logic       set;
        logic [7:0] sec;
        logic [7:0] last;
    } t_map_ctl;

    // bitmap status back to the tracker
    typedef struct packed {
        logic seen;
        logic all_done;
    } t_map_sts;

    function automatic logic [2:0] kind_of(input logic [7:0] tid);
        logic [2:0] k;
        case (tid)
            TID_PAT:     k = KIND_PAT;
            TID_PMT:     k = KIND_PMT;
            TID_NIT_ACT: k = KIND_NIT;
            TID_NIT_OTH: k = KIND_NIT;
            TID_SDT_ACT: k = KIND_SDT;
            TID_SDT_OTH: k = KIND_SDT;
            default:     k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/psi_section_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psi_section_tracker
// Tracks the sections of one PSI table from decoded section header fields.
// ----------------------------------------------------------------------------
// Path: the input transaction is held in the input register, then evaluated
//   into the result register; a stalled result holds both in place.
// Throughput: one transaction per cycle when the result is not stalled; set by
//   the single evaluation stage, updating tracking state and bitmap in the same cycle.
// Reset: synchronous, active low; clears tracking, bitmap, done flag,
//   configuration and both valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
module psi_section_tracker #(
    parameter int MAX_SECTIONS = 256
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // configuration write port
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_index,
    input  wire  [7:0]               i_cfg_data,
    // section header channel
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire psist_pkg::t_sec_in  i_in_data,
    // result channel
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output psist_pkg::t_sec_out      o_out_data
);

    // configuration
    logic [7:0]  r_exp_tid;
    logic        r_segmented;

    // input register
    logic                r_in_vld;
    psist_pkg::t_sec_in  r_in;

    // tracking state
    logic        r_trk_vld;
    logic [15:0] r_trk_ext;
    logic [4:0]  r_trk_ver;
    logic        r_done;
    logic        n_done;

    // result register
    logic                r_out_vld;
    psist_pkg::t_sec_out r_out;
    psist_pkg::t_sec_out n_out;

    // evaluation
    logic                fire;
    logic                accept;
    logic                match;
    logic                restart;
    logic                trunc;
    logic                is_new;
    psist_pkg::t_map_ctl map_ctl;
    psist_pkg::t_map_sts map_sts;

    // evaluation fires when the result register is free or being drained
    assign fire       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_tid   <= '0;
            r_segmented <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psist_pkg::CFG_EXP_TID:   r_exp_tid   <= i_cfg_data;
                psist_pkg::CFG_SEGMENTED: r_segmented <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // ---- section evaluation ----
    // A rejected section touches nothing. A version or extension change (or
    // the very first accepted section) restarts tracking and wipes the map,
    // even if the section turns out to be truncated.
    assign match   = (r_in.tbl_id == r_exp_tid);
    assign restart = match && (!r_trk_vld
                               || (r_in.ver_num != r_trk_ver)
                               || (r_in.tbl_ext != r_trk_ext));
    assign trunc   = (r_in.sec_len < psist_pkg::HDR_CRC_LEN);

    // marking a section that is already set leaves the map as it is
    assign map_ctl = '{clear: fire && restart,
                       set:   fire && match && !trunc,
                       sec:   r_in.sec_num,
                       last:  r_in.last_sec};

    always_comb begin
        // map_sts.seen already reflects the clear of this cycle
        is_new = match && !trunc && !map_sts.seen;

        n_done = restart ? 1'b0 : r_done;
        if (is_new && map_sts.all_done) begin
            n_done = 1'b1;
        end

        n_out = '0;
        if (!match) begin
            n_out.status = psist_pkg::ST_REJECT;
        end else begin
            n_out.version_reset = restart;
            if (trunc) begin
                n_out.status = psist_pkg::ST_TRUNCATED;
            end else begin
                n_out.payload_length = r_in.sec_len - psist_pkg::HDR_CRC_LEN;
                n_out.table_complete = n_done && !r_segmented;
                if (is_new) begin
                    n_out.status     = psist_pkg::ST_NEW;
                    n_out.table_kind = psist_pkg::kind_of(r_in.tbl_id);
                end else begin
                    n_out.status = psist_pkg::ST_SEEN;
                end
            end
        end
    end

    psist_bitmap #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (map_ctl),
        .o_sts   (map_sts)
    );

    // ---- tracking state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk_vld <= 1'b0;
            r_trk_ext <= '0;
            r_trk_ver <= '0;
            r_done    <= 1'b0;
        end else if (fire && match) begin
            if (restart) begin
                r_trk_vld <= 1'b1;
                r_trk_ext <= r_in.tbl_ext;
                r_trk_ver <= r_in.ver_num;
            end
            r_done <= n_done;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // a rejected section reports nothing but its status
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == psist_pkg::ST_REJECT)
        |-> !o_out_data.version_reset && (o_out_data.table_kind == psist_pkg::KIND_OTHER)
            && (o_out_data.payload_length == '0) && !o_out_data.table_complete)
        else $error("rejected section carries nonzero fields");

    // a rejected section leaves tracking untouched
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !match
        |=> $stable(r_trk_ext) && $stable(r_trk_ver) && $stable(r_done))
        else $error("rejected section changed tracking state");

    // a held input item is not dropped
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !fire |=> r_in_vld)
        else $error("input item lost while result stalled");

    // completion is never reported in segmented mode
    a_segmented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_segmented |-> !n_out.table_complete)
        else $error("completion reported in segmented mode");
`endif

endmodule
`default_nettype wire

// ===== rtl/psist_bitmap.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psist_bitmap
// Sections-seen bitmap: clear on restart, mark, and masked completion check.
// ----------------------------------------------------------------------------
module psist_bitmap #(
    parameter int MAX_SECTIONS = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire psist_pkg::t_map_ctl   i_ctl,
    output psist_pkg::t_map_sts        o_sts
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam logic [8:0] MAX_W9 = 9'(MAX_SECTIONS);

    logic [MAX_SECTIONS-1:0] r_seen;
    logic [MAX_SECTIONS-1:0] n_seen;
    logic [MAX_SECTIONS-1:0] seen_eff;
    logic [MAX_SECTIONS-1:0] mask;
    logic [IDX_W-1:0]        idx;
    logic                    sec_ok;
    logic                    last_ok;

    always_comb begin
        seen_eff = i_ctl.clear ? '0 : r_seen;
        sec_ok   = {1'b0, i_ctl.sec} < MAX_W9;
        last_ok  = {1'b0, i_ctl.last} < MAX_W9;
        idx      = i_ctl.sec[IDX_W-1:0];

        n_seen = seen_eff;
        if (i_ctl.set && sec_ok) begin
            n_seen[idx] = 1'b1;
        end

        // sections 0..last
        for (int i = 0; i < MAX_SECTIONS; i++) begin
            mask[i] = (9'(i) <= {1'b0, i_ctl.last});
        end

        o_sts.seen     = sec_ok && seen_eff[idx];
        o_sts.all_done = last_ok && (&(n_seen | ~mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

endmodule
`default_nettype wire

// ===== tb/psist_checker.sv =====
// ----------------------------------------------------------------------------
// psist_checker
// Watches both channels and the register port of the PSI section tracker,
// keeps its own copy of tracking state, predicts one result per accepted
// section header and compares results field by field in order.
// ----------------------------------------------------------------------------
module psist_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [7:0]           i_cfg_data,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  psist_pkg::t_sec_in  i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  psist_pkg::t_sec_out i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    psist_pkg::t_sec_out expected_q[$];
    logic                tracking;
    logic [15:0]         trk_ext;
    logic [4:0]          trk_ver;
    logic [255:0]        seen_map;
    logic                table_done;
    logic [7:0]          cfg_tid;
    logic                cfg_segmented;
    int                  errors = 0;

    assign o_fail_count = errors;

    function automatic logic [2:0] table_kind_for(input logic [7:0] tid);
        case (tid)
            psist_pkg::TID_PAT:     return psist_pkg::KIND_PAT;
            psist_pkg::TID_PMT:     return psist_pkg::KIND_PMT;
            psist_pkg::TID_NIT_ACT,
            psist_pkg::TID_NIT_OTH: return psist_pkg::KIND_NIT;
            psist_pkg::TID_SDT_ACT,
            psist_pkg::TID_SDT_OTH: return psist_pkg::KIND_SDT;
            default:                return psist_pkg::KIND_OTHER;
        endcase
    endfunction

    // updates tracking state and returns the result one header produces
    function automatic psist_pkg::t_sec_out track_section(input psist_pkg::t_sec_in hdr);
        psist_pkg::t_sec_out r;
        logic                all_seen;
        r = '0;
        if (hdr.tbl_id != cfg_tid) begin
            r.status = psist_pkg::ST_REJECT;
            return r;
        end
        if (!tracking || hdr.ver_num != trk_ver || hdr.tbl_ext != trk_ext) begin
            tracking        = 1'b1;
            trk_ver         = hdr.ver_num;
            trk_ext         = hdr.tbl_ext;
            table_done      = 1'b0;
            seen_map        = '0;
            r.version_reset = 1'b1;
        end
        if (hdr.sec_len < psist_pkg::HDR_CRC_LEN) begin
            r.status = psist_pkg::ST_TRUNCATED;
            return r;
        end
        r.payload_length = hdr.sec_len - psist_pkg::HDR_CRC_LEN;
        if (seen_map[hdr.sec_num]) begin
            r.status = psist_pkg::ST_SEEN;
        end else begin
            seen_map[hdr.sec_num] = 1'b1;
            r.status     = psist_pkg::ST_NEW;
            r.table_kind = table_kind_for(hdr.tbl_id);
            all_seen     = 1'b1;
            for (int k = 0; k <= int'(hdr.last_sec); k++)
                if (!seen_map[k]) all_seen = 1'b0;
            if (all_seen) table_done = 1'b1;
        end
        r.table_complete = table_done && !cfg_segmented;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        psist_pkg::t_sec_out want;
        if (!i_rst_n) begin
            tracking      = 1'b0;
            trk_ext       = '0;
            trk_ver       = '0;
            seen_map      = '0;
            table_done    = 1'b0;
            cfg_tid       = '0;
            cfg_segmented = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == psist_pkg::CFG_EXP_TID) cfg_tid = i_cfg_data;
                else                                       cfg_segmented = i_cfg_data[0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result transaction with none expected, actual %h",
                             $time, i_out_data);
                    errors++;
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    check_field("status", 12'(want.status), 12'(i_out_data.status));
                    check_field("version_reset", 12'(want.version_reset),
                                12'(i_out_data.version_reset));
                    check_field("table_kind", 12'(want.table_kind),
                                12'(i_out_data.table_kind));
                    check_field("payload_length", want.payload_length,
                                i_out_data.payload_length);
                    check_field("table_complete", 12'(want.table_complete),
                                12'(i_out_data.table_complete));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_q.insert(expected_q.size(), track_section(i_in_data));
        end
        o_pending <= expected_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the PSI section tracker. A directed part covers
// field extremes, every status and table kind, restarts and segmented mode;
// a random part then sends mostly well-formed tables (shuffled sections,
// repeats, truncations, version breaks) mixed with foreign sections, under
// random gaps and stalls, across several register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEMS   = 1900;
    localparam logic [7:0]  PAT     = psist_pkg::TID_PAT;
    localparam logic [11:0] MIN_LEN = psist_pkg::HDR_CRC_LEN;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = psist_pkg::CFG_EXP_TID;
    logic [7:0]          cfg_data  = '0;
    logic                in_valid  = 1'b0;
    psist_pkg::t_sec_in  in_data   = '0;
    logic                in_stall;
    logic                out_valid;
    logic                out_stall = 1'b0;
    psist_pkg::t_sec_out out_data;
    int                  fail_count;
    int                  pending;

    // run state shared by the stimulus tasks
    bit          calm     = 1'b0;   // no gaps and no stalls while set
    int          sent     = 0;      // accepted header transactions
    logic [7:0]  cur_tid  = PAT;
    logic [15:0] prev_ext = '0;
    logic [4:0]  prev_ver = '0;

    psi_section_tracker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    psist_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop; the slowest legal run stays far below this.
    initial begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: per transaction, optionally hold stall high, then lower it and take
    // the next result. Stall may be high with nothing on the channel.
    initial begin : result_sink
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // One header transaction: optional gap with valid low, then hold the
    // payload until accepted. Valid stays high into the next call when
    // there is no gap, so it is never dropped and raised in one step.
    task automatic send(input psist_pkg::t_sec_in hdr);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= hdr;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Stop sending until every predicted result has come back. The first
    // edge lets the checker count the last accepted header; the tail
    // covers the two-stage pipeline.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Lowers the enable on its own edge so back-to-back writes never put
    // two assignments on cfg_we in one step.
    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] tid, input logic seg);
        drain();
        write_reg(psist_pkg::CFG_EXP_TID, tid);
        write_reg(psist_pkg::CFG_SEGMENTED, {7'd0, seg});
        cur_tid = tid;
    endtask

    function automatic psist_pkg::t_sec_in mk(input logic [7:0] tid, input logic [15:0] ext,
                                              input logic [4:0] ver, input logic [7:0] sec,
                                              input logic [7:0] last, input logic [11:0] len);
        psist_pkg::t_sec_in h;
        h.tbl_id   = tid;
        h.tbl_ext  = ext;
        h.ver_num  = ver;
        h.sec_num  = sec;
        h.last_sec = last;
        h.sec_len  = len;
        return h;
    endfunction

    // Section of the current table with a random length; now and then
    // truncated or at the length extremes.
    function automatic psist_pkg::t_sec_in sec_hdr(input logic [15:0] ext,
                                                   input logic [4:0] ver,
                                                   input logic [7:0] sec,
                                                   input logic [7:0] last);
        logic [11:0] len;
        case ($urandom_range(0, 19))
            0:       len = 12'($urandom_range(0, 8));
            1:       len = MIN_LEN;
            2:       len = 12'hfff;
            default: len = 12'($urandom_range(9, 4095));
        endcase
        return mk(cur_tid, ext, ver, sec, last, len);
    endfunction

    // Fully random header; usually a foreign table id, sometimes ours so it
    // breaks into the tracked table.
    function automatic psist_pkg::t_sec_in noise();
        logic [63:0]        r;
        psist_pkg::t_sec_in h;
        r = {$urandom, $urandom};
        h = r[$bits(psist_pkg::t_sec_in)-1:0];
        if ($urandom_range(0, 3) == 0) h.tbl_id = cur_tid;
        return h;
    endfunction

    // One table: sections 0..last in shuffled order, with repeats, a rare
    // version break, a stray last section number and foreign sections mixed in.
    task automatic send_table();
        logic [15:0] ext;
        logic [4:0]  ver;
        logic [7:0]  last;
        logic [7:0]  lst;
        logic [7:0]  t;
        logic [7:0]  order [256];
        int          n;
        int          cnt;
        int          j;
        int          pick;
        ext  = ($urandom_range(0, 2) == 0) ? prev_ext : 16'($urandom);
        ver  = ($urandom_range(0, 2) == 0) ? prev_ver : 5'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 14)      last = 8'($urandom_range(0, 7));
        else if (pick < 18) last = 8'($urandom_range(8, 31));
        else                last = 8'($urandom_range(32, 255));
        n = int'(last) + 1;
        for (int k = 0; k < n; k++) order[k] = 8'(k);
        for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        cnt = (n > 40) ? 40 : n;   // long tables are left unfinished
        for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(0, 11) == 0) send(noise());
            if (k > 0 && $urandom_range(0, 9) == 0)
                send(sec_hdr(ext, ver, order[$urandom_range(0, k - 1)], last));
            if ($urandom_range(0, 29) == 0) ver = ver + 5'd1;
            lst = ($urandom_range(0, 15) == 0) ? 8'($urandom) : last;
            send(sec_hdr(ext, ver, order[k], lst));
        end
        prev_ext = ext;
        prev_ver = ver;
    endtask

    initial begin : stimulus
        int         phase_end;
        int         p;
        logic [7:0] tid;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        configure(PAT, 1'b0);
        // first section after reset restarts tracking; one-section table completes
        send(mk(PAT, 16'h0000, 5'd0, 8'd0, 8'd0, MIN_LEN));
        send(mk(PAT, 16'h0000, 5'd0, 8'd0, 8'd0, MIN_LEN));        // already seen
        send(mk(8'hff, 16'hffff, 5'd31, 8'hff, 8'hff, 12'hfff));   // rejected
        send(mk(PAT, 16'h0000, 5'd0, 8'd1, 8'd1, 12'd0));          // truncated
        send(mk(PAT, 16'h0000, 5'd0, 8'd1, 8'd1, 12'd8));          // truncated at edge
        send(mk(PAT, 16'h0000, 5'd0, 8'd1, 8'd1, 12'hfff));        // new, completes
        send(mk(PAT, 16'hffff, 5'd0, 8'hff, 8'hff, 12'd10));       // extension change
        send(mk(PAT, 16'hffff, 5'd31, 8'd0, 8'd0, MIN_LEN));       // version change
        send(mk(PAT, 16'hffff, 5'd31, 8'd0, 8'd0, 12'd3));         // truncated, no restart
        send(mk(PAT, 16'h0000, 5'd31, 8'd5, 8'd0, 12'd4));         // restart plus truncated
        send(mk(PAT, 16'h0000, 5'd31, 8'd0, 8'd2, 12'd9));         // partial table
        // segmented mode hides completion; the done flag survives the switch back
        configure(PAT, 1'b1);
        send(mk(PAT, 16'h0001, 5'd1, 8'd0, 8'd0, 12'd20));
        send(mk(PAT, 16'h0001, 5'd1, 8'd0, 8'd0, 12'd20));
        configure(PAT, 1'b0);
        send(mk(PAT, 16'h0001, 5'd1, 8'd0, 8'd0, 12'd20));
        // each table kind, plus a neighboring id that must be rejected
        for (int k = 0; k < 6; k++) begin
            case (k)
                0:       tid = psist_pkg::TID_PMT;
                1:       tid = psist_pkg::TID_NIT_ACT;
                2:       tid = psist_pkg::TID_NIT_OTH;
                3:       tid = psist_pkg::TID_SDT_ACT;
                4:       tid = psist_pkg::TID_SDT_OTH;
                default: tid = 8'hff;
            endcase
            configure(tid, 1'b0);
            send(mk(tid, 16'h1234, 5'd3, 8'(k), 8'd9, 12'd100));
            send(mk(tid ^ 8'h01, 16'h1234, 5'd3, 8'(k), 8'd9, 12'd100));
        end

        // ---- random part: phases under different register settings ----
        p = 0;
        while (sent < ITEMS) begin
            if (p == 0)                         tid = 8'hff;
            else if (p == 1)                    tid = PAT;
            else if ($urandom_range(0, 2) == 0) tid = 8'($urandom);
            else begin
                case ($urandom_range(0, 5))
                    0:       tid = psist_pkg::TID_PAT;
                    1:       tid = psist_pkg::TID_PMT;
                    2:       tid = psist_pkg::TID_NIT_ACT;
                    3:       tid = psist_pkg::TID_NIT_OTH;
                    4:       tid = psist_pkg::TID_SDT_ACT;
                    default: tid = psist_pkg::TID_SDT_OTH;
                endcase
            end
            configure(tid, (p % 3) == 2);
            // some phases run back to back with no gaps or stalls at all
            calm      = ($urandom_range(0, 3) == 0);
            phase_end = sent + 118;
            while (sent < phase_end) begin
                case ($urandom_range(0, 19))
                    0, 1:    send(noise());
                    2:       drain();   // hold off until all results are back
                    default: send_table();
                endcase
            end
            p++;
        end

        calm = 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
